### rtl/cpts_pkg.sv
// Shared constants, command codes and control/status structs for the cue point table search.
// Has no dependencies. The rtl/cpts_* modules other than cpts_ram import it.
package cpts_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int CMD_W   = 3;
  localparam int TIME_W  = 32;
  localparam int TAG_W   = 16;
  localparam int FILT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int ENTRY_W = TIME_W + 1 + TAG_W;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEAREST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PREV    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd5;

  localparam logic [FILT_W-1:0] FILT_START = 2'd1;
  localparam logic [FILT_W-1:0] FILT_STOP  = 2'd2;

  typedef struct packed {
    logic load;
    logic issue;
    logic shift;
    logic put;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
  } stat_t;

endpackage

### rtl/cue_point_table_search.sv
// Cue point table search: a table of up to TABLE_DEPTH timeline cue points (time, type, id)
// kept in one single-port-read RAM, with sorted insert, clear, nearest/next/previous search
// and update-by-id. One command is in flight at a time, and a finished result waits in the
// output register while the next command is taken. Entries are read one per cycle from the
// RAM: a search or update scans every valid entry, an insert scans for the slot and then
// shifts the tail one entry per cycle, and clear, a refused insert or an unused code skip
// the scan. Depends on cpts_pkg, cpts_ctrl, cpts_dpath and cpts_ram.
module cue_point_table_search #(
  parameter int TABLE_DEPTH = cpts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cpts_pkg::CMD_W-1:0]   command,
  input  logic [cpts_pkg::TIME_W-1:0]  time_ms,
  input  logic                         point_kind,
  input  logic [cpts_pkg::TAG_W-1:0]   point_tag,
  input  logic [cpts_pkg::FILT_W-1:0]  kind_filter,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [cpts_pkg::TIME_W-1:0]  hit_time,
  output logic                         hit_kind,
  output logic [cpts_pkg::TAG_W-1:0]   hit_tag,
  output logic                         table_full,
  output logic [cpts_pkg::COUNT_W-1:0] entry_count
);
  import cpts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ctrl_t         ctrl;
  stat_t         stat;
  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  logic [AW-1:0] rd_addr;

  cpts_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .count     (count),
    .pos       (pos),
    .ctrl      (ctrl),
    .rd_addr   (rd_addr)
  );

  cpts_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .rd_addr     (rd_addr),
    .stat        (stat),
    .count       (count),
    .pos         (pos),
    .command     (command),
    .time_ms     (time_ms),
    .point_kind  (point_kind),
    .point_tag   (point_tag),
    .kind_filter (kind_filter),
    .found       (found),
    .hit_time    (hit_time),
    .hit_kind    (hit_kind),
    .hit_tag     (hit_tag),
    .table_full  (table_full),
    .entry_count (entry_count)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while a command is in flight");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.issue |-> CW'(rd_addr) < count)
    else $error("table read beyond valid entries");

  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !found && hit_tag == '0)
    else $error("refused insert reports a hit");

endmodule

### rtl/cpts_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/cpts_ctrl.sv
// Command sequencer: scan, shift and write-back phases, plus the handshake control.
// Depends on cpts_pkg.
module cpts_ctrl #(
  parameter int TABLE_DEPTH = cpts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  output logic                             out_valid,
  input  logic                             out_stall,
  input  cpts_pkg::stat_t                  stat,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   pos,
  output cpts_pkg::ctrl_t                  ctrl,
  output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr
);
  import cpts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SCAN, S_SWAIT, S_SHIFT, S_HWAIT, S_PUT, S_FINISH
  } state_t;

  state_t        state;
  logic [CW-1:0] c;
  logic [CW-1:0] c_dec;
  logic          scan_cmd;
  logic          out_free;

  assign c_dec    = c - CW'(1);
  assign out_free = !out_valid || !out_stall;
  assign scan_cmd = (stat.cmd == CMD_INSERT && !stat.full) || stat.cmd == CMD_NEAREST ||
                    stat.cmd == CMD_NEXT || stat.cmd == CMD_PREV || stat.cmd == CMD_UPDATE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      c         <= '0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_START;
        end
        S_START: begin
          c     <= '0;
          state <= scan_cmd ? S_SCAN : S_FINISH;
        end
        S_SCAN: begin
          if (c < count) c <= c + CW'(1);
          else state <= S_SWAIT;
        end
        S_SWAIT: begin
          c     <= count;
          state <= (stat.cmd == CMD_INSERT) ? S_SHIFT : S_FINISH;
        end
        S_SHIFT: begin
          if (c > CW'(pos)) c <= c_dec;
          else state <= S_HWAIT;
        end
        S_HWAIT: state <= S_PUT;
        S_PUT:   state <= S_FINISH;
        S_FINISH: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall    = (state != S_IDLE);
  assign ctrl.load   = in_valid && (state == S_IDLE);
  assign ctrl.issue  = (state == S_SCAN && c < count) || (state == S_SHIFT && c > CW'(pos));
  assign ctrl.shift  = (state == S_SHIFT);
  assign ctrl.put    = (state == S_PUT);
  assign ctrl.finish = (state == S_FINISH) && out_free;
  assign rd_addr     = (state == S_SHIFT) ? c_dec[AW-1:0] : c[AW-1:0];

endmodule

### rtl/cpts_dpath.sv
// Datapath: entry RAM, command latch, scan evaluation, shift/insert/update writes, result registers.
// Depends on cpts_pkg and cpts_ram.
module cpts_dpath #(
  parameter int TABLE_DEPTH = cpts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cpts_pkg::ctrl_t                  ctrl,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
  output cpts_pkg::stat_t                  stat,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] count,
  output logic [$clog2(TABLE_DEPTH)-1:0]   pos,
  input  logic [cpts_pkg::CMD_W-1:0]       command,
  input  logic [cpts_pkg::TIME_W-1:0]      time_ms,
  input  logic                             point_kind,
  input  logic [cpts_pkg::TAG_W-1:0]       point_tag,
  input  logic [cpts_pkg::FILT_W-1:0]      kind_filter,
  output logic                             found,
  output logic [cpts_pkg::TIME_W-1:0]      hit_time,
  output logic                             hit_kind,
  output logic [cpts_pkg::TAG_W-1:0]       hit_tag,
  output logic                             table_full,
  output logic [cpts_pkg::COUNT_W-1:0]     entry_count
);
  import cpts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [CMD_W-1:0]   cmd_q;
  logic [TIME_W-1:0]  t_q;
  logic               kind_q;
  logic [TAG_W-1:0]   tag_q;
  logic [FILT_W-1:0]  filt_q;
  logic               full_q;

  logic               p_valid;
  logic               p_shift;
  logic [AW-1:0]      p_idx;

  logic               hit;
  logic [TIME_W-1:0]  best_time;
  logic               best_kind;
  logic [TAG_W-1:0]   best_tag;
  logic [TIME_W-1:0]  best_d;

  logic [ENTRY_W-1:0] rd_data;
  logic [TIME_W-1:0]  e_time;
  logic               e_kind;
  logic [TAG_W-1:0]   e_tag;
  logic [TIME_W-1:0]  d;
  logic               kind_ok;
  logic               take;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;

  logic               search;

  cpts_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctrl.issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign e_time = rd_data[ENTRY_W-1 -: TIME_W];
  assign e_kind = rd_data[TAG_W];
  assign e_tag  = rd_data[TAG_W-1:0];
  assign d      = (e_time >= t_q) ? (e_time - t_q) : (t_q - e_time);

  always_comb begin
    case (filt_q)
      FILT_START: kind_ok = e_kind;
      FILT_STOP:  kind_ok = !e_kind;
      default:    kind_ok = 1'b1;
    endcase
  end

  always_comb begin
    take = 1'b0;
    if (p_valid && !p_shift) begin
      case (cmd_q)
        CMD_NEAREST: take = !hit || (d < best_d);
        CMD_NEXT:    take = !hit && (e_time > t_q) && kind_ok;
        CMD_PREV:    take = (e_time < t_q);
        default:     take = 1'b0;
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = p_idx;
    wdata = {t_q, kind_q, e_tag};
    if (ctrl.put) begin
      we    = 1'b1;
      waddr = pos;
      wdata = {t_q, kind_q, tag_q};
    end else if (p_valid && p_shift) begin
      we    = 1'b1;
      waddr = p_idx + AW'(1);
      wdata = rd_data;
    end else if (p_valid && cmd_q == CMD_UPDATE && e_tag == tag_q) begin
      we    = 1'b1;
    end
  end

  assign search = (cmd_q == CMD_NEAREST) || (cmd_q == CMD_NEXT) || (cmd_q == CMD_PREV);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      p_valid <= 1'b0;
      hit     <= 1'b0;
      cmd_q   <= CMD_CLEAR;
      full_q  <= 1'b0;
    end else begin
      p_valid <= ctrl.issue;
      if (ctrl.load) begin
        cmd_q  <= command;
        full_q <= (command == CMD_INSERT) && (count == CW'(TABLE_DEPTH));
        hit    <= 1'b0;
        if (command == CMD_CLEAR) count <= '0;
      end else begin
        if (ctrl.put) count <= count + CW'(1);
        if (take) hit <= 1'b1;
        if (p_valid && !p_shift && cmd_q == CMD_UPDATE && e_tag == tag_q) hit <= 1'b1;
        if (p_valid && !p_shift && cmd_q == CMD_INSERT && !hit && e_time > t_q) hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_shift <= ctrl.shift;
    p_idx   <= rd_addr;
    if (ctrl.load) begin
      t_q    <= time_ms;
      kind_q <= point_kind;
      tag_q  <= point_tag;
      filt_q <= kind_filter;
      pos    <= count[AW-1:0];
    end
    if (p_valid && !p_shift && cmd_q == CMD_INSERT && !hit && e_time > t_q) begin
      pos <= p_idx;
    end
    if (take) begin
      best_time <= e_time;
      best_kind <= e_kind;
      best_tag  <= e_tag;
      best_d    <= d;
    end
    if (ctrl.finish) begin
      found       <= hit && (search || cmd_q == CMD_UPDATE);
      hit_time    <= (search && hit) ? best_time :
                     (cmd_q == CMD_NEAREST) ? t_q : '0;
      hit_kind    <= search && hit && best_kind;
      hit_tag     <= (search && hit) ? best_tag : '0;
      table_full  <= full_q;
      entry_count <= COUNT_W'(count);
    end
  end

  assign stat.cmd  = cmd_q;
  assign stat.full = full_q;

endmodule
